@@ hdl/zvd_pkg.sv @@
// ----------------------------------------------------------------------------
// zvd_pkg
// Types, constants and control records shared by the zero-velocity detector.
// ----------------------------------------------------------------------------
package zvd_pkg;

    localparam int WINDOW_DEF = 16;
    localparam int STAT_W     = 48;

    localparam logic [1:0] REG_GRAVITY     = 2'd0;
    localparam logic [1:0] REG_INV_SIGMA_A = 2'd1;
    localparam logic [1:0] REG_INV_SIGMA_G = 2'd2;
    localparam logic [1:0] REG_THRESHOLD   = 2'd3;

    localparam logic [15:0] GRAVITY_RST     = 16'd2511;
    localparam logic [23:0] INV_SIGMA_A_RST = 24'd59578;
    localparam logic [23:0] INV_SIGMA_G_RST = 24'd1877454;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVICT,
        ST_MAG,
        ST_SQRT,
        ST_DEV,
        ST_MUL,
        ST_SUM,
        ST_OUT
    } zvd_state_t;

    typedef struct packed {
        logic load;       // latch sample, read oldest entry
        logic evict;      // subtract oldest entry, add new one, write ring
        logic mag_step;   // accumulate one axis of |Sa|^2
        logic sqrt_init;
        logic sqrt_step;
        logic dev;
        logic mul;
        logic sum;
        logic out_load;
    } zvd_cmd_t;

    typedef struct packed {
        logic mag_last;
        logic sqrt_done;
        logic warm;
    } zvd_status_t;

endpackage

@@ hdl/zvd_ctrl.sv @@
// ----------------------------------------------------------------------------
// zvd_ctrl
// Sequencer: steps one sample through root, weighting and window update.
// ----------------------------------------------------------------------------
module zvd_ctrl
    import zvd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        out_busy,
    input  zvd_status_t stat,
    output zvd_cmd_t    cmd
);

    zvd_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // judge on the old window first, then fold the new sample in
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_MAG;
            ST_MAG: begin
                if (stat.warm)          state_next = ST_EVICT;
                else if (stat.mag_last) state_next = ST_SQRT;
            end
            ST_SQRT:  if (stat.sqrt_done) state_next = ST_DEV;
            ST_DEV:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_EVICT;
            ST_EVICT: state_next = ST_OUT;
            ST_OUT:   if (!out_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_MAG: begin
                cmd.mag_step  = !stat.warm;
                cmd.sqrt_init = !stat.warm && stat.mag_last;
            end
            ST_SQRT:  cmd.sqrt_step = 1'b1;
            ST_DEV:   cmd.dev = 1'b1;
            ST_MUL:   cmd.mul = 1'b1;
            ST_SUM:   cmd.sum = 1'b1;
            ST_EVICT: cmd.evict = 1'b1;
            ST_OUT:   cmd.out_load = !out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ hdl/zvd_datapath.sv @@
// ----------------------------------------------------------------------------
// zvd_datapath
// Sample ring, running sums, bit-serial root and weighted statistic.
// ----------------------------------------------------------------------------
module zvd_datapath
    import zvd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [95:0]         s_sample,
    input  logic [15:0]         gravity,
    input  logic [23:0]         inv_sigma_a,
    input  logic [23:0]         inv_sigma_g,
    input  logic [STAT_W-1:0]   threshold,
    input  zvd_cmd_t            cmd,
    output zvd_status_t         stat,
    output logic                res_stationary,
    output logic                res_warming_up,
    output logic [STAT_W-1:0]   res_statistic
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 2);
    localparam int SW = 16 + $clog2(WINDOW) + 1;   // signed accel sum
    localparam int QW = 31 + $clog2(WINDOW) + 1;   // square sums
    localparam int MW = 2 * SW + 2;                // |Sa|^2
    localparam int RW = (MW + 1) / 2;              // root
    localparam int IW = $clog2(RW + 1);            // root step count
    localparam int DW = 62;                        // deviation (signed)
    localparam int DP = QW + 1;                    // positive deviation bound
    localparam int GW = RW + 17;                   // 2*gravity*root

    logic [95:0]    ring_mem [WINDOW];
    logic [95:0]    old_reg;
    logic [95:0]    new_reg;
    logic [PW-1:0]  wp_reg;
    logic [CW-1:0]  seen_reg;
    logic signed [SW-1:0] sa_reg [3];
    logic [QW-1:0]  sa2_reg, sg_reg;
    logic [1:0]     ax_reg;
    logic [MW-1:0]  mag_reg;
    logic [RW-1:0]  root_reg;
    logic [IW-1:0]  it_reg;
    logic signed [DW-1:0] dev_reg;
    logic [DP+23:0] acc_reg;
    logic [QW+23:0] gyr_reg;
    logic           warm_reg;

    // ring memory
    always_ff @(posedge aclk) begin
        if (cmd.load) old_reg <= ring_mem[wp_reg];
        if (cmd.evict) ring_mem[wp_reg] <= new_reg;
    end

    function automatic logic [31:0] sq16(input logic [15:0] v);
        logic signed [15:0] s;
        logic signed [31:0] p;
        s = v;
        p = s * s;
        return p;
    endfunction

    logic evict_old;
    assign evict_old = (seen_reg >= CW'(WINDOW));

    logic [QW-1:0] sa2_add, sa2_sub, sg_add, sg_sub;
    always_comb begin
        sa2_add = QW'(sq16(new_reg[15:0])) + QW'(sq16(new_reg[31:16]))
                + QW'(sq16(new_reg[47:32]));
        sg_add  = QW'(sq16(new_reg[63:48])) + QW'(sq16(new_reg[79:64]))
                + QW'(sq16(new_reg[95:80]));
        sa2_sub = evict_old ? QW'(sq16(old_reg[15:0])) + QW'(sq16(old_reg[31:16]))
                + QW'(sq16(old_reg[47:32])) : '0;
        sg_sub  = evict_old ? QW'(sq16(old_reg[63:48])) + QW'(sq16(old_reg[79:64]))
                + QW'(sq16(old_reg[95:80])) : '0;
    end

    // one axis of |Sa|^2 per cycle
    logic [SW-1:0] ax_abs;
    always_comb begin
        logic signed [SW-1:0] v;
        v = sa_reg[ax_reg];
        ax_abs = v[SW-1] ? SW'(-v) : SW'(v);
    end
    assign stat.mag_last  = (ax_reg == 2'd2);
    assign stat.sqrt_done = (it_reg == IW'(1));
    assign stat.warm      = warm_reg;

    // bit-serial root: two radicand bits per step
    logic [RW+1:0] part_reg;
    logic [RW+2:0] part_next;
    assign part_next = {part_reg[RW:0], mag_reg[MW-1 -: 2]};

    logic [47:0] g2w;
    assign g2w = 48'(WINDOW) * 48'(gravity) * 48'(gravity);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg   <= '0;
            seen_reg <= '0;
            sa_reg   <= '{default: '0};
            sa2_reg  <= '0;
            sg_reg   <= '0;
            ax_reg   <= '0;
            it_reg   <= '0;
            warm_reg <= 1'b1;
        end else begin
            if (cmd.load) begin
                new_reg  <= s_sample;
                warm_reg <= (seen_reg <= CW'(WINDOW));
                mag_reg  <= '0;
                ax_reg   <= '0;
            end
            if (cmd.evict) begin
                for (int k = 0; k < 3; k++) begin
                    sa_reg[k] <= sa_reg[k] + SW'($signed(new_reg[16*k +: 16]))
                               - (evict_old ? SW'($signed(old_reg[16*k +: 16])) : '0);
                end
                sa2_reg <= sa2_reg + sa2_add - sa2_sub;
                sg_reg  <= sg_reg + sg_add - sg_sub;
                wp_reg  <= (wp_reg == PW'(WINDOW - 1)) ? '0 : wp_reg + 1'b1;
                if (seen_reg <= CW'(WINDOW)) seen_reg <= seen_reg + 1'b1;
            end
            if (cmd.mag_step) begin
                mag_reg <= mag_reg + MW'(ax_abs) * MW'(ax_abs);
                ax_reg  <= ax_reg + 1'b1;
            end
            if (cmd.sqrt_init) begin
                it_reg   <= IW'(RW);
                root_reg <= '0;
                part_reg <= '0;
            end
            if (cmd.sqrt_step) begin
                if (part_next >= {1'b0, root_reg, 2'b01}) begin
                    part_reg <= (RW+2)'(part_next - {1'b0, root_reg, 2'b01});
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    part_reg <= part_next[RW+1:0];
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
                mag_reg <= mag_reg << 2;
                it_reg  <= it_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dev)
            dev_reg <= $signed(DW'(sa2_reg)) + $signed(DW'(g2w))
                     - $signed(DW'(GW'({gravity, 1'b0}) * GW'(root_reg)));
        if (cmd.mul) begin
            acc_reg <= dev_reg[DW-1] ? '0
                     : (DP+24)'(dev_reg[DP-1:0]) * (DP+24)'(inv_sigma_a);
            gyr_reg <= (QW+24)'(sg_reg) * (QW+24)'(inv_sigma_g);
        end
        if (cmd.sum) begin
            logic [DW+24:0] g8, t;
            g8 = (DW+25)'(gyr_reg >> 8);
            t  = (DW+25)'(acc_reg) + g8;
            res_statistic <= (t[DW+24:STAT_W] != '0) ? '1 : t[STAT_W-1:0];
        end
        if (cmd.evict && warm_reg) res_statistic <= '0;
    end

    assign res_warming_up = warm_reg;
    assign res_stationary = warm_reg | (res_statistic < threshold);

endmodule

@@ hdl/zero_velocity_glrt_detector.sv @@
// ----------------------------------------------------------------------------
// zero_velocity_glrt_detector
// GLRT zero-velocity detector over a sliding window of 6-axis IMU words.
// ----------------------------------------------------------------------------
// Sequence from an accepted word to m_tvalid at WINDOW=16: three
//   |Sa|^2 steps, 22 root steps (one root bit per cycle), then weight, sum,
//   window update and output load.
// One word at a time: a new sample word is taken only after the last result
// is loaded into the output register. Warm-up words skip the statistic.
// Reset (aresetn low, synchronous) clears sums, counters and registers to
//   defaults; the sample ring is not cleared, only written entries are used.
module zero_velocity_glrt_detector
    import zvd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // test_statistic
    output logic [1:0]  m_tuser,   // stationary, warming_up
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [15:0]       gravity_reg;
    logic [23:0]       isa_reg, isg_reg;
    logic [STAT_W-1:0] thr_reg;
    zvd_cmd_t          cmd;
    zvd_status_t       stat;
    logic              r_stat, r_warm;
    logic [STAT_W-1:0] r_t;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RST;
            isa_reg     <= INV_SIGMA_A_RST;
            isg_reg     <= INV_SIGMA_G_RST;
            thr_reg     <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRAVITY:     gravity_reg <= cfg_data[15:0];
                REG_INV_SIGMA_A: isa_reg     <= cfg_data[23:0];
                REG_INV_SIGMA_G: isg_reg     <= cfg_data[23:0];
                REG_THRESHOLD:   thr_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    zvd_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .out_busy(m_tvalid & ~m_tready), .stat, .cmd
    );

    zvd_datapath #(.WINDOW(WINDOW)) u_dp (
        .aclk, .aresetn, .s_sample(s_tdata),
        .gravity(gravity_reg), .inv_sigma_a(isa_reg), .inv_sigma_g(isg_reg),
        .threshold(thr_reg), .cmd, .stat,
        .res_stationary(r_stat), .res_warming_up(r_warm), .res_statistic(r_t)
    );

    // output register: hold the word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid <= 1'b1;
                m_tdata  <= r_t;
                m_tuser  <= {r_warm, r_stat};
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

endmodule

@@ verif/zvd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zvd_checker
// Watches the sample, result and register channels of the detector, keeps a
// shadow of its window sums and registers, predicts every result word and
// compares it field by field with what the block sends.
// ----------------------------------------------------------------------------
module zvd_checker
    import zvd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    localparam logic [47:0] SAT48 = '1;

    typedef struct packed {
        logic        stationary;
        logic        warming_up;
        logic [47:0] stat;
    } zvd_result_t;

    zvd_result_t result_q[$];

    logic [15:0] gravity_r;
    logic [23:0] isa_r, isg_r;
    logic [47:0] thresh_r;

    longint ring [WINDOW][6];
    int     wr_ptr, seen;
    longint asum [3];
    longint asq, gsq;

    assign pending = result_q.size();

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [47:0] glrt_stat();
        longint unsigned mag2, r, g, acc_t, gyr_t, t;
        longint dev;
        mag2 = 0;
        for (int k = 0; k < 3; k++)
            mag2 += longint'(asum[k] * asum[k]);
        r = int_root(mag2);
        g = gravity_r;
        dev = asq + longint'(WINDOW * g * g) - longint'(2 * g * r);
        acc_t = dev > 0 ? longint'(dev) * isa_r : 0;
        gyr_t = (gsq * isg_r) >> 8;
        if (acc_t > SAT48 || gyr_t > SAT48) return SAT48;
        t = acc_t + gyr_t;
        return t > SAT48 ? SAT48 : t[47:0];
    endfunction

    task automatic absorb_sample(input logic [95:0] d);
        longint s [6];
        zvd_result_t e;
        bit warm;
        for (int k = 0; k < 6; k++) s[k] = longint'($signed(d[16*k +: 16]));
        warm = seen <= WINDOW;
        e.stat = warm ? 48'd0 : glrt_stat();
        e.warming_up = warm;
        e.stationary = warm || (e.stat < thresh_r);
        result_q = {result_q, e};
        // evict the oldest sample once the ring is full
        if (seen >= WINDOW) begin
            for (int k = 0; k < 3; k++) begin
                asum[k] -= ring[wr_ptr][k];
                asq -= ring[wr_ptr][k] * ring[wr_ptr][k];
                gsq -= ring[wr_ptr][k+3] * ring[wr_ptr][k+3];
            end
        end
        for (int k = 0; k < 3; k++) begin
            asum[k] += s[k];
            asq += s[k] * s[k];
            gsq += s[k+3] * s[k+3];
        end
        for (int k = 0; k < 6; k++) ring[wr_ptr][k] = s[k];
        wr_ptr = (wr_ptr + 1) % WINDOW;
        if (seen < WINDOW + 1) seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            gravity_r <= GRAVITY_RST;
            isa_r     <= INV_SIGMA_A_RST;
            isg_r     <= INV_SIGMA_G_RST;
            thresh_r  <= '0;
            wr_ptr = 0;
            seen = 0;
            asq = 0;
            gsq = 0;
            for (int k = 0; k < 3; k++) asum[k] = 0;
            result_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GRAVITY:     gravity_r <= cfg_data[15:0];
                    REG_INV_SIGMA_A: isa_r     <= cfg_data[23:0];
                    REG_INV_SIGMA_G: isg_r     <= cfg_data[23:0];
                    REG_THRESHOLD:   thresh_r  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) absorb_sample(s_tdata);
            if (m_tvalid && m_tready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected result word");
                    fail_count <= fail_count + 1;
                end else begin
                    zvd_result_t e;
                    int bad;
                    e = result_q.pop_front();
                    bad = 0;
                    if (m_tuser[0] !== e.stationary) begin
                        $error("stationary exp %0d got %0d", e.stationary, m_tuser[0]);
                        bad++;
                    end
                    if (m_tuser[1] !== e.warming_up) begin
                        $error("warming_up exp %0d got %0d", e.warming_up, m_tuser[1]);
                        bad++;
                    end
                    if (m_tdata !== e.stat) begin
                        $error("test_statistic exp %0d got %0d", e.stat, m_tdata);
                        bad++;
                    end
                    if (bad != 0) fail_count <= fail_count + 1;
                end
            end
        end
    end
endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the zero-velocity detector with directed and random IMU words under
// several register settings and idle patterns; the checker predicts results.
// ----------------------------------------------------------------------------
module tb;
    import zvd_pkg::*;

    localparam int MAX_CYCLES = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready;
    logic [95:0] s_tdata;   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic        m_tvalid, m_tready;
    logic [47:0] m_tdata;   // test_statistic
    logic [1:0]  m_tuser;   // stationary, warming_up
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [47:0] cfg_data;
    int          fail_count, pending;
    int          src_idle_pct, sink_stall_pct;
    longint      cycles;

    zero_velocity_glrt_detector uut (.*);

    zvd_checker chk (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // cycle limit: ends a hung run
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > MAX_CYCLES) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // result side: stall at random with the current rate
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // push one sample word; idle first at the current rate, hold valid after
    task automatic send_word(input logic [95:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid, hold until every expected word is back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // write one register; only called while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // a sample near rest: accel close to gravity on a random axis, small noise
    function automatic logic [95:0] near_rest_word();
        logic [95:0] d;
        int ax;
        ax = $urandom_range(2);
        for (int k = 0; k < 6; k++)
            d[16*k +: 16] = 16'($signed($urandom_range(80)) - 40);
        d[16*ax +: 16] = 16'(2511 + $signed($urandom_range(60)) - 30);
        return d;
    endfunction

    function automatic logic [95:0] random_word();
        logic [95:0] d;
        case ($urandom_range(3))
            0: d = near_rest_word();
            1: d = {$urandom, $urandom, $urandom};
            2: begin
                for (int k = 0; k < 6; k++)
                    d[16*k +: 16] = 16'($signed($urandom_range(4000)) - 2000);
            end
            default: begin
                d = near_rest_word();
                for (int k = 3; k < 6; k++) d[16*k +: 16] = 16'($urandom);
            end
        endcase
        return d;
    endfunction

    // one phase: a source idle rate, a sink stall rate and a run of words
    task automatic run_phase(input int n, input int idle, input int stall);
        src_idle_pct   = idle;
        sink_stall_pct = stall;
        for (int i = 0; i < n; i++) send_word(random_word());
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_GRAVITY;
        cfg_data  = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: warm-up, zero accel sum, extremes of every field
        for (int i = 0; i < 17; i++) send_word('0);
        send_word('0);
        send_word({6{16'h7FFF}});
        send_word({6{16'h8000}});
        send_word({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_word({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'd2511});
        send_word({16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001});
        drain();

        // default registers, large threshold so stationary can go both ways
        write_reg(REG_THRESHOLD, 48'd4000000000);
        run_phase(300, 0, 0);
        drain();

        // extreme registers: overflow saturation and a full threshold
        write_reg(REG_GRAVITY, 48'hFFFF);
        write_reg(REG_INV_SIGMA_A, 48'hFF_FFFF);
        write_reg(REG_INV_SIGMA_G, 48'hFF_FFFF);
        write_reg(REG_THRESHOLD, 48'hFFFF_FFFF_FFFF);
        run_phase(250, 72, 0);
        drain();

        // zero weights and gravity: clamp and zero paths
        write_reg(REG_GRAVITY, 48'd0);
        write_reg(REG_INV_SIGMA_A, 48'd0);
        write_reg(REG_INV_SIGMA_G, 48'd0);
        write_reg(REG_THRESHOLD, 48'd0);
        run_phase(200, 0, 72);
        drain();

        // random settings near the defaults
        write_reg(REG_GRAVITY, 48'(2400 + $urandom_range(200)));
        write_reg(REG_INV_SIGMA_A, 48'($urandom_range(200000)));
        write_reg(REG_INV_SIGMA_G, 48'($urandom_range(4000000)));
        write_reg(REG_THRESHOLD, {16'($urandom_range(3)), 32'($urandom)});
        run_phase(250, 15, 15);
        drain();

        write_reg(REG_GRAVITY, 48'(16'($urandom)));
        write_reg(REG_THRESHOLD, {$urandom, 16'($urandom)});
        run_phase(280, 0, 0);

        drain();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ files.f @@
hdl/zvd_pkg.sv
hdl/zvd_ctrl.sv
hdl/zvd_datapath.sv
hdl/zero_velocity_glrt_detector.sv
verif/zvd_checker.sv
verif/tb.sv
